>>> hdl/sbdp_pkg.sv
// Package: shared types, codes and reset values of the single-button dimmer.
package sbdp_pkg;

    localparam int BYTE_W = 8;

    // Request commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_LOAD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_LOAD_PTR   = 2'd2;

    // LED patterns
    localparam logic [2:0] PAT_NONE       = 3'd0;
    localparam logic [2:0] PAT_LONG_BLINK = 3'd1;
    localparam logic [2:0] PAT_ENTER      = 3'd2;
    localparam logic [2:0] PAT_LEAVE      = 3'd3;
    localparam logic [2:0] PAT_COUNT      = 3'd4;

    // Store write kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_POINTER = 2'd1;
    localparam logic [1:0] KIND_TABLE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_PRESS     = 2'd0;
    localparam logic [1:0] CFG_SETTINGS_PRESS = 2'd1;
    localparam logic [1:0] CFG_LEVEL_MAX      = 2'd2;

    // Reset values and fixed constants
    localparam logic [7:0] LONG_PRESS_RST     = 8'd8;
    localparam logic [7:0] SETTINGS_PRESS_RST = 8'd20;
    localparam logic [7:0] LEVEL_MAX_RST      = 8'd15;
    localparam logic [7:0] TICKS_MAX          = 8'hFF;
    localparam logic [7:0] TICK_SHORT         = 8'd1;
    localparam logic [7:0] TICK_BACK          = 8'd3;
    localparam logic [4:0] POINTER_FIRST      = 5'd1;
    localparam logic [4:0] COUNT_RST          = 5'd1;

    typedef struct packed {
        logic [1:0] command;
        logic       button_pressed;
        logic [4:0] load_index;
        logic [7:0] load_value;
    } in_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       power_on;
        logic       settings_mode;
        logic [2:0] led_pattern;
        logic [4:0] blink_times;
        logic [1:0] store_kind;
        logic [4:0] store_offset;
        logic [7:0] store_data;
        logic       last;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

endpackage

>>> hdl/single_button_dimmer_preset_control_unit.sv
// Top level: single-button dimmer with preset table, settings recording and store save.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    sbdp_pkg::in_t   (tick or load request)
//  m_        out        m_valid / m_ready    sbdp_pkg::out_t  (status, store write, last)
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  A load request goes straight to its result; a tick runs the long-press and settings
//  checks first; a short or back press before them makes two dependent preset-table
//  reads in normal mode, or steps the edit level in settings mode. On leaving it, each saved
//  byte is one record-buffer read followed by one result and one preset-table write.
//  Reset (aresetn low, synchronous) clears all control state and the valid bits of both
//  memories, so the table and buffer read as zero at once; no clearing pass is needed.
//  A stalled m_ready holds the sequencer at its next result; one request is in work
//  at a time, and the next is taken while the last result still sits in the output reg.
module single_button_dimmer_preset_control_unit #(
    parameter int TABLE_ENTRIES = 17
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sbdp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sbdp_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    sbdp_pkg::cfg_wr_t cfg;
    sbdp_pkg::out_t    emit_data;
    logic              emit_valid;
    logic              emit_ready;

    logic                        tbl_wr_en, tbl_rd_en;
    logic [AW-1:0]               tbl_wr_addr, tbl_rd_addr;
    logic [sbdp_pkg::BYTE_W-1:0] tbl_wr_data, tbl_rd_data;
    logic                        buf_wr_en, buf_rd_en;
    logic [AW-1:0]               buf_wr_addr, buf_rd_addr;
    logic [sbdp_pkg::BYTE_W-1:0] buf_wr_data, buf_rd_data;

    logic           m_valid_reg;
    sbdp_pkg::out_t m_data_reg;

    // configuration writes are always taken, whatever the sequencer is doing
    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;

    sbdp_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .cfg         (cfg),
        .emit_valid  (emit_valid),
        .emit_ready  (emit_ready),
        .emit_data   (emit_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .buf_rd_en   (buf_rd_en),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data)
    );

    // preset table: entry zero is the preset count, entries upward are duty values
    sbdp_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // recording buffer: levels appended in settings mode, saved on leave
    sbdp_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_record (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // output register: load when empty or draining, hold while m_ready is low
    assign emit_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_valid && emit_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid && emit_ready) begin
            m_data_reg <= emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/sbdp_ram.sv
// Byte memory with one write port, one registered read port and per-entry valid bits.
module sbdp_ram #(
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [sbdp_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [sbdp_pkg::BYTE_W-1:0] rd_data
);

    logic [sbdp_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [sbdp_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> hdl/sbdp_seq.sv
// Sequencer: press counter, scalar state and read-modify-write steps on the two memories.
module sbdp_seq #(
    parameter int TABLE_ENTRIES = 17,
    parameter int AW            = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sbdp_pkg::in_t               in_data,
    input  sbdp_pkg::cfg_wr_t           cfg,
    output logic                        emit_valid,
    input  logic                        emit_ready,
    output sbdp_pkg::out_t              emit_data,
    output logic                        tbl_wr_en,
    output logic [AW-1:0]               tbl_wr_addr,
    output logic [sbdp_pkg::BYTE_W-1:0] tbl_wr_data,
    output logic                        tbl_rd_en,
    output logic [AW-1:0]               tbl_rd_addr,
    input  logic [sbdp_pkg::BYTE_W-1:0] tbl_rd_data,
    output logic                        buf_wr_en,
    output logic [AW-1:0]               buf_wr_addr,
    output logic [sbdp_pkg::BYTE_W-1:0] buf_wr_data,
    output logic                        buf_rd_en,
    output logic [AW-1:0]               buf_rd_addr,
    input  logic [sbdp_pkg::BYTE_W-1:0] buf_rd_data
);

    localparam logic [4:0]    MAX_COUNT =
        5'((TABLE_ENTRIES - 1 < 31) ? TABLE_ENTRIES - 1 : 31);
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_ENTRIES - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CNT_RD = 4'd1;
    localparam logic [3:0] ST_PTR    = 4'd2;
    localparam logic [3:0] ST_DUTY   = 4'd3;
    localparam logic [3:0] ST_EDIT   = 4'd4;
    localparam logic [3:0] ST_LONG   = 4'd5;
    localparam logic [3:0] ST_SET    = 4'd6;
    localparam logic [3:0] ST_SAVE   = 4'd7;
    localparam logic [3:0] ST_SWRD   = 4'd8;
    localparam logic [3:0] ST_SWWR   = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [7:0]    long_press_reg, settings_press_reg, level_max_reg;
    logic [7:0]    press_ticks_reg, press_ticks_next;
    logic          light_on_reg, light_on_next;
    logic          recording_reg, recording_next;
    logic [4:0]    pointer_reg, pointer_next;
    logic [7:0]    edit_level_reg, edit_level_next;
    logic [4:0]    record_count_reg, record_count_next;
    logic [7:0]    duty_reg, duty_next;
    logic          ev1_reg, ev1_next;
    logic          evl_reg, evl_next;
    logic          evs_reg, evs_next;
    logic [2:0]    pattern_reg, pattern_next;
    logic [4:0]    blinks_reg, blinks_next;
    logic [1:0]    emit_kind_reg, emit_kind_next;
    logic [7:0]    emit_byte_reg, emit_byte_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic       in_fire;
    logic       fired;
    logic [7:0] ticks_inc;
    logic [4:0] ptr_step;
    logic [4:0] count_step;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign ticks_inc = press_ticks_reg + 8'd1;
    assign fired     = (in_data.command == sbdp_pkg::CMD_TICK) && in_data.button_pressed
                       && (press_ticks_reg != sbdp_pkg::TICKS_MAX);

    always_comb begin
        state_next        = state_reg;
        press_ticks_next  = press_ticks_reg;
        light_on_next     = light_on_reg;
        recording_next    = recording_reg;
        pointer_next      = pointer_reg;
        edit_level_next   = edit_level_reg;
        record_count_next = record_count_reg;
        duty_next         = duty_reg;
        ev1_next          = ev1_reg;
        evl_next          = evl_reg;
        evs_next          = evs_reg;
        pattern_next      = pattern_reg;
        blinks_next       = blinks_reg;
        emit_kind_next    = emit_kind_reg;
        emit_byte_next    = emit_byte_reg;
        hit_next          = hit_reg;
        idx_next          = idx_reg;
        ptr_step          = pointer_reg;
        count_step        = record_count_reg;

        tbl_wr_en   = 1'b0;
        tbl_wr_addr = '0;
        tbl_wr_data = '0;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = '0;
        buf_wr_en   = 1'b0;
        buf_wr_addr = '0;
        buf_wr_data = '0;
        buf_rd_en   = 1'b0;
        buf_rd_addr = '0;

        // every result carries the status left by the whole request
        emit_valid              = 1'b0;
        emit_data.duty          = duty_reg;
        emit_data.power_on      = light_on_reg;
        emit_data.settings_mode = recording_reg;
        emit_data.led_pattern   = pattern_reg;
        emit_data.blink_times   = (pattern_reg == sbdp_pkg::PAT_COUNT) ? blinks_reg : '0;
        emit_data.store_kind    = sbdp_pkg::KIND_NONE;
        emit_data.store_offset  = '0;
        emit_data.store_data    = '0;
        emit_data.last          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    pattern_next   = sbdp_pkg::PAT_NONE;
                    blinks_next    = '0;
                    emit_kind_next = sbdp_pkg::KIND_NONE;
                    emit_byte_next = '0;
                    ev1_next       = fired && (ticks_inc == sbdp_pkg::TICK_SHORT);
                    evl_next       = fired && (ticks_inc == long_press_reg);
                    evs_next       = fired && (ticks_inc == settings_press_reg);
                    state_next     = ST_EMIT;
                    case (in_data.command)
                        sbdp_pkg::CMD_TICK: begin
                            if (!in_data.button_pressed) begin
                                press_ticks_next = '0;
                            end else if (fired) begin
                                press_ticks_next = ticks_inc;
                            end
                            if (fired && (ticks_inc == sbdp_pkg::TICK_SHORT
                                          || ticks_inc == sbdp_pkg::TICK_BACK)) begin
                                state_next = recording_reg ? ST_EDIT : ST_CNT_RD;
                            end else begin
                                state_next = ST_LONG;
                            end
                        end
                        sbdp_pkg::CMD_LOAD_ENTRY: begin
                            if (int'(in_data.load_index) < TABLE_ENTRIES) begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_addr = AW'(in_data.load_index);
                                tbl_wr_data = in_data.load_value;
                            end
                        end
                        sbdp_pkg::CMD_LOAD_PTR: begin
                            pointer_next = in_data.load_value[4:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CNT_RD: begin
                // fetch the preset count (entry zero)
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = '0;
                state_next  = ST_PTR;
            end
            ST_PTR: begin
                if (ev1_reg && light_on_reg) begin
                    ptr_step = ({3'b000, pointer_reg} != tbl_rd_data)
                               ? 5'(pointer_reg + 5'd1) : sbdp_pkg::POINTER_FIRST;
                end else if (ev1_reg) begin
                    light_on_next = 1'b1;
                    pattern_next  = sbdp_pkg::PAT_LONG_BLINK;
                end else begin
                    ptr_step = (pointer_reg != sbdp_pkg::POINTER_FIRST)
                               ? 5'(pointer_reg - 5'd1) : tbl_rd_data[4:0];
                end
                pointer_next = ptr_step;
                hit_next     = int'(ptr_step) < TABLE_ENTRIES;
                tbl_rd_en    = int'(ptr_step) < TABLE_ENTRIES;
                tbl_rd_addr  = AW'(ptr_step);
                state_next   = ST_DUTY;
            end
            ST_DUTY: begin
                duty_next  = hit_reg ? tbl_rd_data : '0;
                state_next = ST_LONG;
            end
            ST_EDIT: begin
                if (ev1_reg) begin
                    edit_level_next = (edit_level_reg >= level_max_reg)
                                      ? '0 : 8'(edit_level_reg + 8'd1);
                end else begin
                    edit_level_next = (edit_level_reg != '0)
                                      ? 8'(edit_level_reg - 8'd1) : level_max_reg;
                end
                duty_next  = edit_level_next;
                state_next = ST_LONG;
            end
            ST_LONG: begin
                if (evl_reg && !recording_reg) begin
                    duty_next      = '0;
                    light_on_next  = 1'b0;
                    pattern_next   = sbdp_pkg::PAT_LONG_BLINK;
                    emit_kind_next = sbdp_pkg::KIND_POINTER;
                    emit_byte_next = {3'b000, pointer_reg};
                end else if (evl_reg) begin
                    count_step = (record_count_reg < MAX_COUNT)
                                 ? 5'(record_count_reg + 5'd1) : record_count_reg;
                    record_count_next = count_step;
                    buf_wr_en         = int'(count_step) < TABLE_ENTRIES;
                    buf_wr_addr       = AW'(count_step);
                    buf_wr_data       = edit_level_reg;
                    pattern_next      = sbdp_pkg::PAT_COUNT;
                    blinks_next       = count_step;
                end
                state_next = ST_SET;
            end
            ST_SET: begin
                state_next = ST_EMIT;
                if (evs_reg && !recording_reg) begin
                    recording_next  = 1'b1;
                    edit_level_next = '0;
                    pattern_next    = sbdp_pkg::PAT_ENTER;
                end else if (evs_reg) begin
                    // close the recording: clear the slot at the record count and step the count back
                    buf_wr_en   = int'(record_count_reg) < TABLE_ENTRIES;
                    buf_wr_addr = AW'(record_count_reg);
                    buf_wr_data = '0;
                    if (record_count_reg != '0) begin
                        record_count_next = 5'(record_count_reg - 5'd1);
                    end
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE: begin
                buf_wr_en      = 1'b1;
                buf_wr_addr    = '0;
                buf_wr_data    = {3'b000, record_count_reg};
                recording_next = 1'b0;
                light_on_next  = 1'b1;
                duty_next      = '0;
                pointer_next   = sbdp_pkg::POINTER_FIRST;
                pattern_next   = sbdp_pkg::PAT_LEAVE;
                emit_kind_next = sbdp_pkg::KIND_POINTER;
                emit_byte_next = {3'b000, sbdp_pkg::POINTER_FIRST};
                idx_next       = '0;
                state_next     = ST_SWRD;
            end
            ST_SWRD: begin
                buf_rd_en   = 1'b1;
                buf_rd_addr = idx_reg;
                state_next  = ST_SWWR;
            end
            ST_SWWR: begin
                // emit one table byte and copy it into the preset table
                emit_valid             = 1'b1;
                emit_data.store_kind   = sbdp_pkg::KIND_TABLE;
                emit_data.store_offset = 5'(32'(idx_reg) + 32'd1);
                emit_data.store_data   = buf_rd_data;
                if (emit_ready) begin
                    tbl_wr_en   = 1'b1;
                    tbl_wr_addr = idx_reg;
                    tbl_wr_data = buf_rd_data;
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_EMIT;
                    end else begin
                        idx_next   = AW'(idx_reg + 1'b1);
                        state_next = ST_SWRD;
                    end
                end
            end
            ST_EMIT: begin
                emit_valid             = 1'b1;
                emit_data.store_kind   = emit_kind_reg;
                emit_data.store_data   = emit_byte_reg;
                emit_data.last         = 1'b1;
                if (emit_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            long_press_reg     <= sbdp_pkg::LONG_PRESS_RST;
            settings_press_reg <= sbdp_pkg::SETTINGS_PRESS_RST;
            level_max_reg      <= sbdp_pkg::LEVEL_MAX_RST;
            press_ticks_reg    <= '0;
            light_on_reg       <= 1'b0;
            recording_reg      <= 1'b0;
            pointer_reg        <= sbdp_pkg::POINTER_FIRST;
            edit_level_reg     <= '0;
            record_count_reg   <= sbdp_pkg::COUNT_RST;
            duty_reg           <= '0;
            ev1_reg            <= 1'b0;
            evl_reg            <= 1'b0;
            evs_reg            <= 1'b0;
            pattern_reg        <= sbdp_pkg::PAT_NONE;
            blinks_reg         <= '0;
            emit_kind_reg      <= sbdp_pkg::KIND_NONE;
            emit_byte_reg      <= '0;
            hit_reg            <= 1'b0;
            idx_reg            <= '0;
        end else begin
            state_reg        <= state_next;
            press_ticks_reg  <= press_ticks_next;
            light_on_reg     <= light_on_next;
            recording_reg    <= recording_next;
            pointer_reg      <= pointer_next;
            edit_level_reg   <= edit_level_next;
            record_count_reg <= record_count_next;
            duty_reg         <= duty_next;
            ev1_reg          <= ev1_next;
            evl_reg          <= evl_next;
            evs_reg          <= evs_next;
            pattern_reg      <= pattern_next;
            blinks_reg       <= blinks_next;
            emit_kind_reg    <= emit_kind_next;
            emit_byte_reg    <= emit_byte_next;
            hit_reg          <= hit_next;
            idx_reg          <= idx_next;
            if (cfg.valid) begin
                case (cfg.index)
                    sbdp_pkg::CFG_LONG_PRESS:     long_press_reg     <= cfg.data;
                    sbdp_pkg::CFG_SETTINGS_PRESS: settings_press_reg <= cfg.data;
                    sbdp_pkg::CFG_LEVEL_MAX:      level_max_reg      <= cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        record_count_reg <= MAX_COUNT)
        else $error("record count past buffer end");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_ready && emit_data.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after final result");

    a_table_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_data.store_kind == sbdp_pkg::KIND_TABLE) |-> !emit_data.last)
        else $error("table byte marked as final result");

    a_leave_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_data.led_pattern == sbdp_pkg::PAT_LEAVE)
        |-> (!recording_reg && light_on_reg && duty_reg == '0))
        else $error("leave status inconsistent");

    a_sweep_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWWR && emit_ready) |-> (tbl_wr_en && tbl_wr_data == buf_rd_data))
        else $error("table copy out of step with save");

endmodule
